/* design/msap_pkg.sv */
package msap_pkg;

  localparam int MAX_TRACK_BYTES = 16384;
  localparam int ADDR_W          = $clog2(MAX_TRACK_BYTES);
  localparam int CNT_W           = ADDR_W + 1;
  localparam int SPT_W           = 6;
  localparam int SECTOR_BYTES    = 512;
  localparam int SPAN_W          = SPT_W + $clog2(SECTOR_BYTES);
  localparam int LONG_RUN        = 4;

  localparam logic [7:0] CODE_BYTE = 8'hE5;
  localparam logic [SPT_W-1:0] SPT_RESET = SPT_W'(9);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_PULL = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLOSE = 5'b00010,
    S_PUT   = 5'b00100,
    S_WAIT  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  // Track size in bytes: zero sectors count as one, capped at the store depth.
  function automatic logic [CNT_W-1:0] track_bytes(input logic [SPT_W-1:0] spt);
    logic [SPAN_W-1:0] s_eff;
    logic [SPAN_W-1:0] full;
    s_eff = (spt == '0) ? SPAN_W'(1) : SPAN_W'(spt);
    full  = s_eff << $clog2(SECTOR_BYTES);
    if (32'(full) > MAX_TRACK_BYTES) begin
      return CNT_W'(MAX_TRACK_BYTES);
    end
    return CNT_W'(full);
  endfunction

endpackage

/* design/msap_ram.sv */
module msap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/msa_track_rle_packer.sv */
// Track packer for the MSA run-length disk image form.
//
// Channels: a config write channel (cfg_valid/cfg_ready, always ready) sets
// sectors_per_track; the input channel (in_valid/in_ready) carries either a
// load transaction (kind = 0, raw_byte) or a pull transaction (kind = 1); the
// output channel (out_valid/out_ready) returns one byte per pull once the
// track is complete: a 2-byte big-endian body length, then the packed or raw
// body, with is_last on the final byte and was_packed on every byte.
//
// Sequencing: a load that extends a run leaves the block idle, ready for the next
// input. A load that ends a run passes through a decision state (S_CLOSE) and
// then, unless the close is skipped, writes each packed byte (up to 4) in S_PUT;
// the load that completes the track closes its final run the same way. The packed
// memory has a single write port, so packed bytes are written one at a time. A pull
// reads the memory and stages the result, loads the output register in S_WAIT and
// presents it in S_OUT; the next input is taken once the result is taken.
// Reset clears all counters and flags and sets sectors_per_track to 9. The
// raw and packed memories are not cleared; only written entries reach the output.
// While out_valid is high and out_ready low, the result holds and in_ready
// stays low.
module msa_track_rle_packer
  import msap_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [SPT_W-1:0] sectors_per_track,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             kind,
  input  logic [7:0]       raw_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             is_last,
  output logic             was_packed
);

  state_t             state;
  logic [SPT_W-1:0]   spt;
  logic [CNT_W-1:0]   loaded_count;
  logic [CNT_W-1:0]   packed_count;
  logic [7:0]         run_value;
  logic [CNT_W-1:0]   run_length;
  logic               pack_overflow;
  logic               draining;
  logic [CNT_W-1:0]   read_position;

  // Close sequencer: which close is running and what follows it.
  logic               first_phase;
  logic               end_pend;
  logic [7:0]         pend_b;
  logic [1:0]         put_idx;
  logic [1:0]         put_last;
  logic               put_coded;

  // Read-out staging.
  logic               sel_hdr;
  logic [7:0]         hdr_byte;
  logic               o_last;
  logic               o_packed;

  logic [7:0]         rd_raw;
  logic [7:0]         rd_packed;

  logic [CNT_W-1:0]   trk;
  logic               accept;
  logic               do_load;
  logic               do_pull;
  logic               stores;
  logic               extend;
  logic [CNT_W-1:0]   loaded_inc;
  logic [CNT_W-1:0]   loaded_after;
  logic               at_end;

  logic               run_coded;
  logic [2:0]         run_n;
  logic [CNT_W:0]     pack_sum;
  logic               close_skip;
  logic               close_done;
  logic [7:0]         put_byte;
  logic               put_we;

  logic               body_packed;
  logic [CNT_W-1:0]   body_len;
  logic [CNT_W:0]     len_plus;
  logic               pull_last;
  logic [CNT_W-1:0]   pos_minus;
  logic [ADDR_W-1:0]  rd_addr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  assign trk     = track_bytes(spt);
  assign accept  = in_valid && in_ready;
  assign do_load = accept && (kind == KIND_LOAD) && !draining;
  assign do_pull = accept && (kind == KIND_PULL) && draining;

  assign stores       = loaded_count < trk;
  assign extend       = (run_length != '0) && (raw_byte == run_value);
  assign loaded_inc   = loaded_count + CNT_W'(1);
  assign loaded_after = stores ? loaded_inc : loaded_count;
  assign at_end       = loaded_after >= trk;

  // Long runs and any run of the code byte go out as a 4-byte code.
  assign run_coded  = (run_length > CNT_W'(LONG_RUN)) || (run_value == CODE_BYTE);
  assign run_n      = run_coded ? 3'(LONG_RUN) : run_length[2:0];
  assign pack_sum   = {1'b0, packed_count} + (CNT_W+1)'(run_n);
  assign close_skip = (run_length == '0) || pack_overflow
                      || (pack_sum >= {1'b0, trk});
  assign close_done = ((state == S_CLOSE) && close_skip)
                      || ((state == S_PUT) && (put_idx == put_last));

  always_comb begin
    put_byte = run_value;
    if (put_coded) begin
      case (put_idx)
        2'd0:    put_byte = CODE_BYTE;
        2'd1:    put_byte = run_value;
        2'd2:    put_byte = 8'(run_length >> 8);
        2'd3:    put_byte = run_length[7:0];
        default: put_byte = run_value;
      endcase
    end
  end

  assign put_we = (state == S_PUT);

  assign body_packed = !pack_overflow && (packed_count < loaded_count);
  assign body_len    = body_packed ? packed_count : loaded_count;
  assign len_plus    = {1'b0, body_len} + (CNT_W+1)'(1);
  assign pull_last   = {1'b0, read_position} >= len_plus;
  assign pos_minus   = read_position - CNT_W'(2);
  assign rd_addr     = pos_minus[ADDR_W-1:0];

  msap_ram #(.WIDTH(8), .DEPTH(MAX_TRACK_BYTES)) u_raw_ram (
    .clk   (clk),
    .we    (do_load && stores),
    .waddr (loaded_count[ADDR_W-1:0]),
    .wdata (raw_byte),
    .re    (do_pull),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  msap_ram #(.WIDTH(8), .DEPTH(MAX_TRACK_BYTES)) u_packed_ram (
    .clk   (clk),
    .we    (put_we),
    .waddr (packed_count[ADDR_W-1:0]),
    .wdata (put_byte),
    .re    (do_pull),
    .raddr (rd_addr),
    .rdata (rd_packed)
  );

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (do_load) begin
      pend_b <= raw_byte;
    end
    if ((state == S_CLOSE) && !close_skip) begin
      put_last  <= 2'(run_n - 3'd1);
      put_coded <= run_coded;
    end
    if (do_pull) begin
      sel_hdr  <= (read_position < CNT_W'(2));
      hdr_byte <= (read_position == '0) ? 8'(body_len >> 8) : body_len[7:0];
      o_last   <= pull_last;
      o_packed <= body_packed;
    end
    if (state == S_WAIT) begin
      out_byte   <= sel_hdr ? hdr_byte : (o_packed ? rd_packed : rd_raw);
      is_last    <= o_last;
      was_packed <= o_packed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      spt           <= SPT_RESET;
      loaded_count  <= '0;
      packed_count  <= '0;
      run_value     <= '0;
      run_length    <= '0;
      pack_overflow <= 1'b0;
      draining      <= 1'b0;
      read_position <= '0;
      first_phase   <= 1'b0;
      end_pend      <= 1'b0;
      put_idx       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        spt <= sectors_per_track;
      end

      case (state)
        S_IDLE: begin
          if (do_load) begin
            if (stores) begin
              loaded_count <= loaded_inc;
            end
            if (stores && extend) begin
              run_length <= run_length + CNT_W'(1);
            end
            // Close the old run first; the new byte starts a run afterward.
            if (stores && !extend) begin
              first_phase <= 1'b1;
              end_pend    <= at_end;
              state       <= S_CLOSE;
            end else if (at_end) begin
              first_phase <= 1'b0;
              end_pend    <= 1'b1;
              state       <= S_CLOSE;
            end
          end else if (do_pull) begin
            if (pull_last) begin
              loaded_count  <= '0;
              packed_count  <= '0;
              run_value     <= '0;
              run_length    <= '0;
              pack_overflow <= 1'b0;
              draining      <= 1'b0;
              read_position <= '0;
            end else begin
              read_position <= read_position + CNT_W'(1);
            end
            state <= S_WAIT;
          end
        end

        S_CLOSE: begin
          if (close_skip) begin
            if (run_length != '0) begin
              pack_overflow <= 1'b1;
            end
          end else begin
            put_idx <= '0;
            state   <= S_PUT;
          end
        end

        S_PUT: begin
          packed_count <= packed_count + CNT_W'(1);
          put_idx      <= put_idx + 2'd1;
        end

        S_WAIT: begin
          state <= S_OUT;
        end

        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // Finish a close: start the pending run, or seal the track.
      if (close_done) begin
        if (first_phase) begin
          run_value   <= pend_b;
          run_length  <= CNT_W'(1);
          first_phase <= 1'b0;
          state       <= end_pend ? S_CLOSE : S_IDLE;
        end else begin
          run_length    <= '0;
          draining      <= 1'b1;
          read_position <= '0;
          end_pend      <= 1'b0;
          state         <= S_IDLE;
        end
      end
    end
  end

endmodule

/* design/msap_checker.sv */
module msap_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       is_last,
  input logic       was_packed
);

  // A pending result blocks new input transactions.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  // A result never appears in the cycle right after an input transaction.
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result appeared too early");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_byte)
      && $stable(is_last) && $stable(was_packed))
    else $error("stalled result changed");

endmodule

bind msa_track_rle_packer msap_checker u_msap_checker (.*);
